### rtl/bmp_pixel_unpacker_assert.svh
// Assertion macros shared by the BMP pixel unpacker modules.
`ifndef BMP_PIXEL_UNPACKER_ASSERT_SVH
`define BMP_PIXEL_UNPACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPU_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPU_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bpu_pkg.sv
// Types and constants shared by the BMP pixel unpacker modules.
package bpu_pkg;

    // Request kinds on the input channel
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    // depth_mode codes
    localparam logic [2:0] MODE_BPP1  = 3'd0;
    localparam logic [2:0] MODE_BPP4  = 3'd1;
    localparam logic [2:0] MODE_BPP8  = 3'd2;
    localparam logic [2:0] MODE_BPP24 = 3'd3;
    localparam logic [2:0] MODE_BPP32 = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_DEPTH_MODE    = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_KEEP_ALPHA    = 3'd3;
    localparam logic [2:0] REG_SWAP_RED_BLUE = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    // Geometry limits and masks
    localparam logic [12:0] MAX_WIDTH_C   = 13'd4096;
    localparam logic [12:0] HEIGHT_LIMIT  = 13'd4096;
    localparam logic [15:0] STRIDE_MASK   = 16'hFFFC;
    localparam logic [31:0] LOW24         = 32'h00FF_FFFF;
    localparam logic [31:0] ALPHA_OPAQUE  = 32'hFF00_0000;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam logic [QPTR_W:0] QCOUNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    typedef struct packed {
        logic        req_type;
        logic [7:0]  palette_index;
        logic [31:0] palette_value;
        logic [7:0]  data_byte;
    } bpu_in_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic [11:0] column;
        logic        last_in_row;
        logic        last_in_image;
    } bpu_out_t;

    typedef struct packed {
        logic [2:0]  depth_mode;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        keep_alpha;
        logic        swap_red_blue;
    } bpu_cfg_t;

    // Work for the back end
    typedef enum logic [2:0] {
        OP_PAL_WRITE,
        OP_BPP1,
        OP_BPP4,
        OP_BPP8,
        OP_DIRECT
    } bpu_op_t;

    typedef struct packed {
        bpu_op_t     op;
        logic [7:0]  index;     // palette write address
        logic [31:0] value;     // palette colour, raw byte or finished direct pixel
        logic [12:0] col;       // column of the first pixel
        logic [3:0]  count;     // pixels in this word, 1..8; 0 for palette writes
        logic        ends_row;  // last pixel of this word closes the row
        logic        last_row;  // word belongs to the final row
    } bpu_cmd_t;

endpackage

### rtl/bpu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/bpu_front.sv
// Front end: accepts words, tracks row position and builds back-end commands.
`include "bmp_pixel_unpacker_assert.svh"
module bpu_front
    import bpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  bpu_in_t  in_word,
    input  bpu_cfg_t cfg,
    input  logic     q_full,
    output logic     push,
    output bpu_cmd_t push_cmd
);
    logic [12:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [15:0] rb_reg, rb_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  pb_reg, pb_next;

    logic [12:0] w_raw, w, h_raw, h, rem, row_inc;
    logic [15:0] data_len, stride, rb_inc;
    logic        accept, is_pix, mode_ok, is_direct, in_row, emit_direct, row_end, last_row;
    logic [3:0]  npix;
    logic [31:0] p24, p32, p_raw, p_fin;
    bpu_op_t     op;
    logic [7:0]  b;

    // Geometry from the registers
    always_comb
    begin
        w_raw = (cfg.image_width == '0) ? 13'd1 : cfg.image_width;
        w     = (w_raw > MAX_WIDTH_C) ? MAX_WIDTH_C : w_raw;
        h_raw = (cfg.image_height == '0) ? 13'd1 : cfg.image_height;
        h     = (h_raw > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_raw;
        case (cfg.depth_mode)
            MODE_BPP1:  data_len = (16'(w) + 16'd7) >> 3;
            MODE_BPP4:  data_len = (16'(w) + 16'd1) >> 1;
            MODE_BPP8:  data_len = 16'(w);
            MODE_BPP24: data_len = (16'(w) << 1) + 16'(w);
            default:    data_len = 16'(w) << 2;
        endcase
        stride = (data_len + 16'd3) & STRIDE_MASK;
    end

    // Classify the word and work out how many pixels it yields
    always_comb
    begin
        b           = in_word.data_byte;
        accept      = in_valid && !q_full;
        is_pix      = (in_word.req_type == REQ_PIXEL);
        mode_ok     = cfg.depth_mode inside {[MODE_BPP1:MODE_BPP32]};
        is_direct   = cfg.depth_mode inside {MODE_BPP24, MODE_BPP32};
        in_row      = (col_reg < w);
        rem         = w - col_reg;
        emit_direct = 1'b0;
        case (cfg.depth_mode)
            MODE_BPP1:
            begin
                op   = OP_BPP1;
                npix = (rem >= 13'd8) ? 4'd8 : rem[3:0];
            end
            MODE_BPP4:
            begin
                op   = OP_BPP4;
                npix = (rem >= 13'd2) ? 4'd2 : 4'd1;
            end
            MODE_BPP8:
            begin
                op   = OP_BPP8;
                npix = 4'd1;
            end
            MODE_BPP24:
            begin
                op          = OP_DIRECT;
                emit_direct = (pb_reg >= 2'd2);
                npix        = emit_direct ? 4'd1 : 4'd0;
            end
            default:
            begin
                op          = OP_DIRECT;
                emit_direct = (pb_reg == 2'd3);
                npix        = emit_direct ? 4'd1 : 4'd0;
            end
        endcase
        if (!in_row)
        begin
            npix = 4'd0;
        end

        // Direct colour assembly, little-endian, optional red/blue swap
        p24   = ((32'(partial_reg) | {8'h00, b, 16'h0000}) & LOW24) | ALPHA_OPAQUE;
        p32   = (32'(partial_reg) & LOW24) | (cfg.keep_alpha ? {b, 24'h0} : ALPHA_OPAQUE);
        p_raw = (cfg.depth_mode == MODE_BPP24) ? p24 : p32;
        p_fin = cfg.swap_red_blue ? {p_raw[31:24], p_raw[7:0], p_raw[15:8], p_raw[23:16]}
                                  : p_raw;

        row_inc  = 13'(row_reg) + 13'd1;
        last_row = (row_inc == h);
        rb_inc   = rb_reg + 16'd1;
        row_end  = (rb_inc >= stride);

        // Command word
        if (!is_pix)
        begin
            push_cmd.op       = OP_PAL_WRITE;
            push_cmd.index    = in_word.palette_index;
            push_cmd.value    = in_word.palette_value;
            push_cmd.col      = '0;
            push_cmd.count    = '0;
            push_cmd.ends_row = 1'b0;
            push_cmd.last_row = 1'b0;
        end
        else
        begin
            push_cmd.op       = op;
            push_cmd.index    = '0;
            push_cmd.value    = is_direct ? p_fin : {24'h0, b};
            push_cmd.col      = col_reg;
            push_cmd.count    = npix;
            push_cmd.ends_row = ((col_reg + 13'(npix)) == w);
            push_cmd.last_row = last_row;
        end
        push = accept && (!is_pix || (mode_ok && (npix != 4'd0)));

        // Position update
        col_next     = col_reg;
        row_next     = row_reg;
        rb_next      = rb_reg;
        partial_next = partial_reg;
        pb_next      = pb_reg;
        if (accept && is_pix && mode_ok)
        begin
            col_next = col_reg + 13'(npix);
            if (in_row && is_direct)
            begin
                if (emit_direct)
                begin
                    partial_next = '0;
                    pb_next      = '0;
                end
                else
                begin
                    case (pb_reg)
                        2'd0:    partial_next[7:0]   = b;
                        2'd1:    partial_next[15:8]  = b;
                        default: partial_next[23:16] = b;
                    endcase
                    pb_next = pb_reg + 2'd1;
                end
            end
            rb_next = rb_inc;
            if (row_end)
            begin
                rb_next      = '0;
                col_next     = '0;
                partial_next = '0;
                pb_next      = '0;
                row_next     = (row_inc >= h) ? 12'd0 : row_inc[11:0];
            end
        end
    end

    assign in_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            rb_reg      <= '0;
            partial_reg <= '0;
            pb_reg      <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            rb_reg      <= rb_next;
            partial_reg <= partial_next;
            pb_reg      <= pb_next;
        end
    end

    // An 8-bit byte inside the row always produces work
    `BPU_ASSERT_IMP(a_bpp8_pushes, clk, rst_n, accept && is_pix && cfg.depth_mode == MODE_BPP8 && col_reg < w, push, "8-bit pixel byte dropped")
endmodule

### rtl/bpu_queue.sv
// Short command queue between the front and back ends.
`include "bmp_pixel_unpacker_assert.svh"
module bpu_queue
    import bpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bpu_cmd_t push_cmd,
    input  logic     pop,
    output logic     head_valid,
    output bpu_cmd_t head,
    output logic     full
);
    bpu_cmd_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rptr_reg];
    assign full       = (count_reg == QCOUNT_FULL);

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wptr_reg] <= push_cmd;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `BPU_ASSERT_IMP(a_push_not_full, clk, rst_n, push, !full, "push into full queue")
    `BPU_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, head_valid, "pop from empty queue")
endmodule

### rtl/bpu_back.sv
// Back end: palette writes and lookups, one pixel per cycle to the output unless stalled.
`include "bmp_pixel_unpacker_assert.svh"
module bpu_back
    import bpu_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  bpu_cmd_t head,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_stall,
    output bpu_out_t out_word
);
    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

    logic [2:0]  k_reg, k_next;
    logic        b_valid_reg, b_valid_next;
    logic        b_use_ram_reg, b_zero_reg, b_lr_reg, b_li_reg;
    logic [31:0] b_direct_reg;
    logic [11:0] b_col_reg;
    logic        out_valid_reg, out_valid_next;
    bpu_out_t    out_word_reg;

    logic        out_free, b_adv, issue, is_write, is_lookup, last_pix, in_range, lr;
    logic [7:0]  byte_v, pal_idx;
    logic [31:0] ram_rdata, b_pixel;

    // Step through the pixels of the head command
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        b_adv     = b_valid_reg && out_free;
        issue     = head_valid && (!b_valid_reg || b_adv);
        is_write  = (head.op == OP_PAL_WRITE);
        is_lookup = head.op inside {OP_BPP1, OP_BPP4, OP_BPP8};
        last_pix  = ((4'(k_reg) + 4'd1) == head.count);
        pop       = issue && (is_write || last_pix);
        k_next    = issue ? (pop ? 3'd0 : k_reg + 3'd1) : k_reg;

        byte_v = head.value[7:0];
        case (head.op)
            OP_BPP1: pal_idx = {7'h00, byte_v[3'd7 - k_reg]};
            OP_BPP4: pal_idx = (k_reg == 3'd0) ? {4'h0, byte_v[7:4]} : {4'h0, byte_v[3:0]};
            OP_BPP8: pal_idx = byte_v;
            default: pal_idx = head.index;
        endcase
        in_range = ({1'b0, pal_idx} < PAL_LIMIT);
        lr       = head.ends_row && last_pix;

        b_valid_next = b_adv ? 1'b0 : b_valid_reg;
        if (issue && !is_write)
        begin
            b_valid_next = 1'b1;
        end
        b_pixel = b_use_ram_reg ? (b_zero_reg ? 32'h0 : ram_rdata) : b_direct_reg;

        out_valid_next = out_valid_reg && out_stall;
        if (b_adv)
        begin
            out_valid_next = 1'b1;
        end
    end

    bpu_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (issue && is_write && in_range),
        .waddr (pal_idx[AW-1:0]),
        .wdata (head.value),
        .re    (issue && is_lookup),
        .raddr (pal_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Lookup stage and output register payload
    always_ff @(posedge clk)
    begin
        if (issue && !is_write)
        begin
            b_use_ram_reg <= is_lookup;
            b_zero_reg    <= !in_range;
            b_direct_reg  <= head.value;
            b_col_reg     <= 12'(head.col + 13'(k_reg));
            b_lr_reg      <= lr;
            b_li_reg      <= lr && head.last_row;
        end
        if (b_adv)
        begin
            out_word_reg.pixel         <= b_pixel;
            out_word_reg.column        <= b_col_reg;
            out_word_reg.last_in_row   <= b_lr_reg;
            out_word_reg.last_in_image <= b_li_reg;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `BPU_ASSERT_IMP(a_image_end_in_row, clk, rst_n, out_valid && out_word.last_in_image, out_word.last_in_row, "image end without row end")
    `BPU_ASSERT_NXT(a_lookup_holds, clk, rst_n, b_valid_reg && !out_free, b_valid_reg && $stable(b_col_reg), "lookup stage lost a pixel")
endmodule

### rtl/bmp_pixel_unpacker.sv
// Top level of the BMP pixel unpacker: registers, front end, queue, back end.
//
// Takes one word per cycle while in_stall is low (a palette write or a byte
// of the padded pixel array); gives 32-bit ARGB pixels, one per cycle while
// out_stall is low, with column and row/image end marks. Palette writes and
// 8/24/32-bit bytes are taken at one per cycle; a 4-bit byte yields up to
// two pixels and a 1-bit byte up to eight, and since the palette RAM gives
// one lookup per cycle the input falls to the pixel rate once the four-word
// command queue is full. A pixel's command passes through the queue, the
// lookup stage and the output register before out_valid rises. Palette
// entries read before they are written give undefined colours; there is no
// clearing pass after reset. The user must write registers through the cfg
// port only while no words are in flight; the block does not enforce this.
module bmp_pixel_unpacker
    import bpu_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bpu_in_t               in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bpu_out_t              out_word
);
    bpu_cfg_t cfg_reg, cfg_next;
    logic     push, pop, head_valid, q_full;
    bpu_cmd_t push_cmd, head;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_DEPTH_MODE:    cfg_next.depth_mode    = cfg_wdata[2:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_wdata[12:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_wdata[12:0];
                REG_KEEP_ALPHA:    cfg_next.keep_alpha    = cfg_wdata[0];
                REG_SWAP_RED_BLUE: cfg_next.swap_red_blue = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_mode    <= MODE_BPP8;
            cfg_reg.image_width   <= 13'd1;
            cfg_reg.image_height  <= 13'd1;
            cfg_reg.keep_alpha    <= 1'b0;
            cfg_reg.swap_red_blue <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    bpu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (q_full)
    );

    bpu_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );
endmodule

### bench/bmp_pixel_unpacker_test.sv
// Self-checking bench for bmp_pixel_unpacker: directed and random words against a local decoder.
import bpu_pkg::*;

// Decoder copy that tracks the colour table and row position and holds the pixels still due
class pixel_ledger;
    logic [31:0] colour_table [256];
    bit          entry_written [256];
    logic [7:0]  written_entries [$];
    int          col_pos;
    int          row_pos;
    int          row_bytes;
    logic [23:0] held_bytes;
    int          held_count;
    // register copies
    logic [2:0]  depth;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    bit          keep_a;
    bit          swap_rb;
    // pixels still to arrive, oldest first
    bpu_out_t    due_pixels [$];
    int          words_seen;
    int          colour_writes;
    int          pixels_matched;
    int          image_ends;
    int          mismatches;

    function new();
        depth = MODE_BPP8;
        width_reg = 13'd1;
        height_reg = 13'd1;
        keep_a = 1'b0;
        swap_rb = 1'b0;
        held_bytes = '0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [12:0] value);
        case (addr)
            REG_DEPTH_MODE:    depth = value[2:0];
            REG_IMAGE_WIDTH:   width_reg = value;
            REG_IMAGE_HEIGHT:  height_reg = value;
            REG_KEEP_ALPHA:    keep_a = value[0];
            REG_SWAP_RED_BLUE: swap_rb = value[0];
            default: ;
        endcase
    endfunction

    // zero counts as one, anything past the limit saturates
    function int clamped(logic [12:0] v, logic [12:0] limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return int'(limit);
        return int'(v);
    endfunction

    function logic [31:0] rb_order(logic [31:0] p);
        return swap_rb ? {p[31:24], p[7:0], p[15:8], p[23:16]} : p;
    endfunction

    function void push_pixel(logic [31:0] colour, int w, int h);
        bpu_out_t e;
        e.pixel = colour;
        e.column = col_pos[11:0];
        e.last_in_row = (col_pos + 1 == w);
        e.last_in_image = e.last_in_row && (row_pos + 1 == h);
        due_pixels.push_back(e);
        col_pos++;
    endfunction

    // works out the pixels one accepted input word gives
    function void unpack_word(bpu_in_t wd);
        int w;
        int h;
        int data_len;
        int stride;
        int k;
        logic [7:0] b;
        words_seen++;
        if (wd.req_type == REQ_PALETTE)
        begin
            colour_table[wd.palette_index] = wd.palette_value;
            colour_writes++;
            if (!entry_written[wd.palette_index])
            begin
                entry_written[wd.palette_index] = 1'b1;
                written_entries.push_back(wd.palette_index);
            end
            return;
        end
        // reserved depth codes drop the byte and leave the position alone
        if (depth > MODE_BPP32)
            return;
        w = clamped(width_reg, MAX_WIDTH_C);
        h = clamped(height_reg, HEIGHT_LIMIT);
        case (depth)
            MODE_BPP1:  data_len = (w + 7) / 8;
            MODE_BPP4:  data_len = (w + 1) / 2;
            MODE_BPP8:  data_len = w;
            MODE_BPP24: data_len = w * 3;
            default:    data_len = w * 4;
        endcase
        stride = (data_len + 3) / 4 * 4;
        b = wd.data_byte;
        // bytes past the last column are row padding
        if (col_pos < w)
        begin
            case (depth)
                MODE_BPP1:
                    for (k = 0; k < 8 && col_pos < w; k++)
                        push_pixel(colour_table[b[7 - k]], w, h);
                MODE_BPP4:
                begin
                    push_pixel(colour_table[b[7:4]], w, h);
                    if (col_pos < w)
                        push_pixel(colour_table[b[3:0]], w, h);
                end
                MODE_BPP8:
                    push_pixel(colour_table[b], w, h);
                MODE_BPP24:
                    if (held_count < 2)
                    begin
                        held_bytes[8 * held_count +: 8] = b;
                        held_count++;
                    end
                    else
                    begin
                        // a third byte left over from 32-bit mode merges into red
                        push_pixel(rb_order({ALPHA_OPAQUE[31:24], b | held_bytes[23:16],
                                             held_bytes[15:0]}), w, h);
                        held_bytes = '0;
                        held_count = 0;
                    end
                default:
                    if (held_count < 3)
                    begin
                        held_bytes[8 * held_count +: 8] = b;
                        held_count++;
                    end
                    else
                    begin
                        push_pixel(rb_order({keep_a ? b : ALPHA_OPAQUE[31:24], held_bytes}),
                                   w, h);
                        held_bytes = '0;
                        held_count = 0;
                    end
            endcase
        end
        // row end once the padded stride is used up; wraps to a new image after the last row
        row_bytes++;
        if (row_bytes >= stride)
        begin
            row_bytes = 0;
            col_pos = 0;
            held_bytes = '0;
            held_count = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function logic [7:0] pick_entry(int limit);
        logic [7:0] choices [$];
        foreach (written_entries[i])
            if (written_entries[i] < limit)
                choices.push_back(written_entries[i]);
        return choices[$urandom_range(0, choices.size() - 1)];
    endfunction

    // next data byte: colour indexes that will be looked up only point at filled entries
    function logic [7:0] next_byte();
        int w;
        logic [3:0] hi;
        logic [3:0] lo;
        w = clamped(width_reg, MAX_WIDTH_C);
        if (col_pos >= w)
            return 8'($urandom);
        case (depth)
            MODE_BPP8:
                return pick_entry(256);
            MODE_BPP4:
            begin
                hi = 4'(pick_entry(16));
                lo = (col_pos + 1 < w) ? 4'(pick_entry(16)) : 4'($urandom);
                return {hi, lo};
            end
            default:
                return 8'($urandom);
        endcase
    endfunction

    task report(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s", what);
    endtask

    task match_pixel(bpu_out_t got);
        bpu_out_t want;
        if (due_pixels.size() == 0)
        begin
            report($sformatf("pixel %08h at column %0d with none due", got.pixel, got.column));
            return;
        end
        want = due_pixels.pop_front();
        pixels_matched++;
        if (want.last_in_image)
            image_ends++;
        if (got.pixel !== want.pixel)
            report($sformatf("pixel %0d: colour %08h, want %08h",
                             pixels_matched, got.pixel, want.pixel));
        if (got.column !== want.column)
            report($sformatf("pixel %0d: column %0d, want %0d",
                             pixels_matched, got.column, want.column));
        if (got.last_in_row !== want.last_in_row)
            report($sformatf("pixel %0d: row end %b, want %b",
                             pixels_matched, got.last_in_row, want.last_in_row));
        if (got.last_in_image !== want.last_in_image)
            report($sformatf("pixel %0d: image end %b, want %b",
                             pixels_matched, got.last_in_image, want.last_in_image));
    endtask
endclass

module bmp_pixel_unpacker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int WORDS_PER_PHASE = 40;
    localparam logic [2:0] MODE_RESERVED_LO = 3'd5;
    localparam logic [2:0] MODE_RESERVED_HI = 3'd7;
    localparam logic [2:0] DEPTH_CYCLE [5] = '{MODE_BPP1, MODE_BPP4, MODE_BPP8,
                                               MODE_BPP24, MODE_BPP32};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    bpu_in_t               in_word = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    bpu_out_t              out_word;

    pixel_ledger ledger = new();
    bit          no_gaps = 1'b0;
    int          stall_hold = 0;
    int          settings_used = 0;
    int          cycle_count = 0;

    bmp_pixel_unpacker dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // cycle counter: ends a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d pixels outstanding.",
                 cycle_count, ledger.due_pixels.size());
        $display("TB_ERROR");
        $finish;
    end

    // result side: check each delivered pixel, then stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && !out_stall)
            begin
                ledger.match_pixel(out_word);
                stall_hold = no_gaps ? 0 : $urandom_range(0, 5);
            end
            else if (stall_hold > 0)
                stall_hold--;
            out_stall <= (stall_hold != 0);
        end
    end

    // one word on the input channel, after a drawn gap; returns at the accepting edge
    task automatic send_word(input bpu_in_t wd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= wd;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        ledger.unpack_word(wd);
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [31:0] value);
        bpu_in_t wd;
        wd.req_type = REQ_PALETTE;
        wd.palette_index = idx;
        wd.palette_value = value;
        wd.data_byte = 8'($urandom);
        send_word(wd);
    endtask

    task automatic send_byte(input logic [7:0] b);
        bpu_in_t wd;
        wd.req_type = REQ_PIXEL;
        wd.palette_index = 8'($urandom);
        wd.palette_value = $urandom;
        wd.data_byte = b;
        send_word(wd);
    endtask

    // hold the sender until every due pixel is back, then wait a little longer
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.due_pixels.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [12:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        ledger.set_reg(addr, value);
    endtask

    task automatic program_regs(input logic [2:0] depth, input logic [12:0] w,
                                input logic [12:0] h, input bit ka, input bit srb);
        settle(SETTLE_CYCLES);
        write_reg(REG_DEPTH_MODE, {10'd0, depth});
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_KEEP_ALPHA, {12'd0, ka});
        write_reg(REG_SWAP_RED_BLUE, {12'd0, srb});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // random phase: one register setting, then a mix of colour writes and data bytes
    task automatic run_phase(input int ph);
        logic [2:0]  depth;
        logic [12:0] w;
        logic [12:0] h;
        int          words;
        int          i;
        case (ph)
            0:
            begin
                depth = MODE_BPP1;
                w = MAX_WIDTH_C;
                h = 13'($urandom_range(1, 3));
            end
            1:
            begin
                depth = MODE_BPP8;
                w = 13'h1FFF;
                h = 13'd0;
            end
            2:
            begin
                depth = 3'($urandom_range(MODE_RESERVED_LO, MODE_RESERVED_HI));
                w = 13'($urandom_range(1, 12));
                h = 13'($urandom_range(1, 3));
            end
            default:
            begin
                depth = DEPTH_CYCLE[ph % 5];
                w = ($urandom_range(0, 3) == 0) ? 13'd1 : 13'($urandom_range(1, 12));
                h = ($urandom_range(0, 5) == 0) ? HEIGHT_LIMIT : 13'($urandom_range(1, 3));
            end
        endcase
        program_regs(depth, w, h, 1'($urandom), 1'($urandom));
        no_gaps = (ph % 3 == 2);
        words = (depth > MODE_BPP32) ? 8 : WORDS_PER_PHASE;
        for (i = 0; i < words; i++)
        begin
            // now and then let the pipeline run dry mid-phase
            if (ph % 4 == 3 && i == words / 2)
                settle(0);
            if ($urandom_range(0, 7) == 0)
                send_palette(8'($urandom), $urandom);
            else
                send_byte(ledger.next_byte());
        end
    endtask

    initial
    begin
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: colour table extremes, one pixel then its row padding
        send_palette(8'd0, 32'h0000_0000);
        send_palette(8'd1, 32'hFFFF_FFFF);
        send_palette(8'd255, 32'h8040_2010);
        send_palette(8'd15, 32'h7F3C_C3A5);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);

        // 1 bpp, width past the limit, height zero: eight pixels per byte, row left open
        program_regs(MODE_BPP1, 13'h1FFF, 13'd0, 1'b0, 1'b0);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);

        // 4 bpp mid-row: byte count already at the new stride ends the row at once
        program_regs(MODE_BPP4, 13'd3, 13'd1, 1'b0, 1'b1);
        send_byte(8'h00);
        send_byte(8'hF0);
        send_byte(8'h1F);
        send_byte(8'h00);
        send_byte(8'h00);

        // 24 bpp, width zero, height past the limit, red and blue swapped
        program_regs(MODE_BPP24, 13'd0, 13'h1FFF, 1'b0, 1'b1);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'hFF);

        // 32 bpp keeping alpha
        program_regs(MODE_BPP32, 13'd1, 13'd1, 1'b1, 1'b0);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h80);

        // reserved depth code: byte is dropped
        program_regs(MODE_RESERVED_HI, 13'd1, 13'd1, 1'b0, 1'b0);
        send_byte(8'h3C);

        for (ph = 0; ph < RANDOM_PHASES; ph++)
            run_phase(ph);

        no_gaps = 1'b0;
        settle(SETTLE_CYCLES);
        $display("Covered %0d input words (%0d colour-table writes) over %0d register settings.",
                 ledger.words_seen, ledger.colour_writes, settings_used);
        $display("Compared %0d pixels including %0d image ends; %0d mismatches.",
                 ledger.pixels_matched, ledger.image_ends, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.due_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/bpu_pkg.sv
rtl/bpu_ram.sv
rtl/bpu_front.sv
rtl/bpu_queue.sv
rtl/bpu_back.sv
rtl/bmp_pixel_unpacker.sv
bench/bmp_pixel_unpacker_test.sv
